FILE: hw/rtl/pitm_pkg.sv
// ----------------------------------------------------------------------------
// pitm_pkg: shared types and constants of the tetrahedral mesh classifier
// Operation codes, field widths and the controller to datapath command bundle.
// ----------------------------------------------------------------------------
`default_nettype none
package pitm_pkg;
    localparam int unsigned OpW = 2;
    localparam int unsigned IdxW = 12;
    localparam int unsigned TypeW = 8;
    localparam int unsigned PoreW = 24;
    localparam int unsigned CntW = 13;

    typedef enum logic [OpW-1:0] {
        OP_LOAD_VERTEX = 2'd0,
        OP_LOAD_TET    = 2'd1,
        OP_QUERY       = 2'd2,
        OP_NONE        = 2'd3
    } op_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;    // latch the query point and type
        logic tet_rd;     // read tetrahedron entry at scan index
        logic vtx_rd;     // read vertex of the selected corner
        logic [1:0] corner; // corner whose vertex is read
        logic grab;       // latch vertex read data of previous corner
        logic [1:0] grab_corner;
        logic face_start; // start a determinant evaluation
        logic [1:0] face;
        logic clear_scan;
        logic next_tet;
    } pitm_cmd_t;

    // Status back to the controller.
    typedef struct packed {
        logic det_done;
        logic det_neg;
        logic last_tet;
        logic empty;
    } pitm_sts_t;
endpackage
`default_nettype wire

FILE: hw/rtl/pitm_stream_if.sv
// ----------------------------------------------------------------------------
// pitm_stream_if: valid/ready channel carrying one request
// Generic payload type so both the input and the result channel can use it.
// ----------------------------------------------------------------------------
`default_nettype none
interface pitm_stream_if #(parameter type payload_t = logic) (input wire logic clk);
    logic     valid;
    logic     ready;
    payload_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/pitm_ram.sv
// ----------------------------------------------------------------------------
// pitm_ram: single port write, single port registered read memory
// Width and depth are set by parameters.
// ----------------------------------------------------------------------------
`default_nettype none
module pitm_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule
`default_nettype wire

FILE: hw/rtl/pitm_det.sv
// ----------------------------------------------------------------------------
// pitm_det: multi-cycle sign of a 3x3 edge determinant
// Computes det(q2-q1, q3-q1, q4-q1) with one multiplier, one product a cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module pitm_det #(
    parameter int unsigned CW = 32
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [3*CW-1:0]   q1,
    input  wire logic [3*CW-1:0]   q2,
    input  wire logic [3*CW-1:0]   q3,
    input  wire logic [3*CW-1:0]   q4,
    output logic                   done,
    output logic                   neg
);
    localparam int unsigned EW = CW + 1;       // edge width
    localparam int unsigned PW = 2 * EW;       // product width
    localparam int unsigned CXW = PW + 1;      // cross term width
    localparam int unsigned LOW = CXW - EW;    // low slice of a cross term
    localparam int unsigned MBW = LOW + 1;     // second multiplier operand width
    localparam int unsigned MPW = EW + MBW;    // multiplier result width
    localparam int unsigned TW = CXW + EW;     // triple product width
    localparam int unsigned SW = TW + 2;       // accumulated sum width

    // Edge registers: e[0]=q2-q1, e[1]=q3-q1, e[2]=q4-q1, per axis.
    logic signed [EW-1:0] e_reg [3][3];
    logic signed [EW-1:0] e_next [3][3];
    logic [3:0] step_reg, step_next;
    logic busy_reg, busy_next;
    logic signed [CXW-1:0] cross_reg, cross_next;
    logic signed [SW-1:0] sum_reg, sum_next;
    logic done_reg, done_next;

    logic signed [EW-1:0] ma;
    logic signed [MBW-1:0] mb;
    logic signed [MPW-1:0] prod;
    logic signed [EW-1:0] cross_hi;
    logic signed [MBW-1:0] cross_lo;

    // The cross term is split so the multiplier stays narrow: the signed upper
    // slice and the unsigned lower slice are each multiplied by the lead edge.
    assign cross_hi = $signed(cross_reg[CXW-1:LOW]);
    assign cross_lo = $signed({1'b0, cross_reg[LOW-1:0]});

    // Schedule: for term t (0..2) steps 4t: a*b, 4t+1: -c*d, 4t+2: lead*upper
    // slice of the cross term, 4t+3: lead*lower slice.
    always_comb
    begin
        ma = '0;
        mb = '0;
        unique case (step_reg)
            4'd0: begin ma = e_reg[1][1]; mb = MBW'(e_reg[2][2]); end
            4'd1: begin ma = e_reg[1][2]; mb = MBW'(e_reg[2][1]); end
            4'd2: begin ma = e_reg[0][0]; mb = MBW'(cross_hi); end
            4'd3: begin ma = e_reg[0][0]; mb = cross_lo; end
            4'd4: begin ma = e_reg[0][2]; mb = MBW'(e_reg[2][1]); end
            4'd5: begin ma = e_reg[0][1]; mb = MBW'(e_reg[2][2]); end
            4'd6: begin ma = e_reg[1][0]; mb = MBW'(cross_hi); end
            4'd7: begin ma = e_reg[1][0]; mb = cross_lo; end
            4'd8: begin ma = e_reg[0][1]; mb = MBW'(e_reg[1][2]); end
            4'd9: begin ma = e_reg[0][2]; mb = MBW'(e_reg[1][1]); end
            4'd10: begin ma = e_reg[2][0]; mb = MBW'(cross_hi); end
            4'd11: begin ma = e_reg[2][0]; mb = cross_lo; end
            default: begin ma = '0; mb = '0; end
        endcase
        prod = MPW'(ma) * MPW'(mb);
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                e_next[i][k] = e_reg[i][k];
            end
        end
        step_next = step_reg;
        busy_next = busy_reg;
        cross_next = cross_reg;
        sum_next = sum_reg;
        done_next = 1'b0;
        if (start)
        begin
            for (int k = 0; k < 3; k++)
            begin
                e_next[0][k] = EW'(signed'(q2[k*CW +: CW])) - EW'(signed'(q1[k*CW +: CW]));
                e_next[1][k] = EW'(signed'(q3[k*CW +: CW])) - EW'(signed'(q1[k*CW +: CW]));
                e_next[2][k] = EW'(signed'(q4[k*CW +: CW])) - EW'(signed'(q1[k*CW +: CW]));
            end
            step_next = '0;
            busy_next = 1'b1;
            sum_next = '0;
        end
        else if (busy_reg)
        begin
            step_next = step_reg + 4'd1;
            unique case (step_reg)
                4'd0, 4'd4, 4'd8: cross_next = CXW'(prod);
                4'd1, 4'd5, 4'd9: cross_next = cross_reg - CXW'(prod);
                4'd2, 4'd6, 4'd10: sum_next = sum_reg + (SW'(prod) <<< LOW);
                4'd3, 4'd7: sum_next = sum_reg + SW'(prod);
                4'd11:
                begin
                    sum_next = sum_reg + SW'(prod);
                    busy_next = 1'b0;
                    done_next = 1'b1;
                end
                default: busy_next = 1'b0;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        e_reg <= e_next;
        cross_reg <= cross_next;
        sum_reg <= sum_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign done = done_reg;
    assign neg = sum_reg[SW-1];
endmodule
`default_nettype wire

FILE: hw/rtl/pitm_datapath.sv
// ----------------------------------------------------------------------------
// pitm_datapath: mesh stores, query point, corner fetch and determinant unit
// Executes the commands of the controller and reports scan status.
// ----------------------------------------------------------------------------
`default_nettype none
module pitm_datapath #(
    parameter int unsigned MAX_VERTICES = 4096,
    parameter int unsigned MAX_TETS = 4096,
    parameter int unsigned CW = 32
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_fire,
    input  wire logic [pitm_pkg::OpW-1:0]     in_op,
    input  wire logic [pitm_pkg::IdxW-1:0]    in_index,
    input  wire logic [3*CW-1:0]              in_point,
    input  wire logic [4*pitm_pkg::IdxW-1:0]  in_corners,
    input  wire logic [pitm_pkg::CntW-1:0]    tet_count,
    input  wire pitm_pkg::pitm_cmd_t          cmd,
    output pitm_pkg::pitm_sts_t               sts,
    output logic [pitm_pkg::IdxW-1:0]         scan_idx
);
    import pitm_pkg::*;
    localparam int unsigned VAW = $clog2(MAX_VERTICES);
    localparam int unsigned TAW = (MAX_TETS > 1) ? $clog2(MAX_TETS) : 1;
    localparam int unsigned TDEPTH = (MAX_TETS > 1) ? MAX_TETS : 2;
    localparam int unsigned SCW = $clog2(MAX_TETS + 1);

    logic [3*CW-1:0] pt_reg;
    logic [3*CW-1:0] vtx_reg [4];
    logic [SCW-1:0] scan_reg;
    logic [3*CW-1:0] vrd;
    logic [4*IdxW-1:0] trd;
    logic [IdxW-1:0] sel_corner;
    logic [3*CW-1:0] q1, q2, q3, q4;
    logic vtx_we, tet_we;
    logic [IdxW:0] limit;
    logic corner_ok_reg;

    assign vtx_we = in_fire && op_t'(in_op) == OP_LOAD_VERTEX
        && 32'(in_index) < MAX_VERTICES;
    assign tet_we = in_fire && op_t'(in_op) == OP_LOAD_TET && 32'(in_index) < MAX_TETS;

    pitm_ram #(.WIDTH(3*CW), .DEPTH(MAX_VERTICES)) u_vtx (
        .clk(clk), .we(vtx_we), .waddr(VAW'(in_index)), .wdata(in_point),
        .re(cmd.vtx_rd), .raddr(VAW'(sel_corner)), .rdata(vrd)
    );

    pitm_ram #(.WIDTH(4*IdxW), .DEPTH(TDEPTH)) u_tet (
        .clk(clk), .we(tet_we), .waddr(TAW'(in_index)), .wdata(in_corners),
        .re(cmd.tet_rd), .raddr(TAW'(scan_reg)), .rdata(trd)
    );

    assign sel_corner = trd[cmd.corner*IdxW +: IdxW];

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            pt_reg <= in_point;
        end
        if (cmd.vtx_rd)
        begin
            corner_ok_reg <= 32'(sel_corner) < MAX_VERTICES;
        end
        if (cmd.grab)
        begin
            vtx_reg[cmd.grab_corner] <= corner_ok_reg ? vrd : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_reg <= '0;
        end
        else if (cmd.clear_scan)
        begin
            scan_reg <= '0;
        end
        else if (cmd.next_tet)
        begin
            scan_reg <= scan_reg + 1'b1;
        end
    end

    // Face order matches the containment test: (2,4,3),(1,3,4),(1,4,2),(1,2,3).
    always_comb
    begin
        unique case (cmd.face)
            2'd0: begin q1 = vtx_reg[1]; q2 = vtx_reg[3]; q3 = vtx_reg[2]; end
            2'd1: begin q1 = vtx_reg[0]; q2 = vtx_reg[2]; q3 = vtx_reg[3]; end
            2'd2: begin q1 = vtx_reg[0]; q2 = vtx_reg[3]; q3 = vtx_reg[1]; end
            default: begin q1 = vtx_reg[0]; q2 = vtx_reg[1]; q3 = vtx_reg[2]; end
        endcase
        q4 = pt_reg;
    end

    pitm_det #(.CW(CW)) u_det (
        .clk(clk), .rst_n(rst_n), .start(cmd.face_start),
        .q1(q1), .q2(q2), .q3(q3), .q4(q4),
        .done(sts.det_done), .neg(sts.det_neg)
    );

    assign limit = (32'(tet_count) > MAX_TETS) ? (IdxW+1)'(MAX_TETS) : tet_count;
    assign sts.empty = (IdxW+1)'(scan_reg) >= limit;
    assign sts.last_tet = (IdxW+1)'(scan_reg) + 1'b1 >= limit;
    assign scan_idx = IdxW'(scan_reg);
endmodule
`default_nettype wire

FILE: hw/rtl/pitm_ctrl.sv
// ----------------------------------------------------------------------------
// pitm_ctrl: sequencer for the tetrahedron scan
// Fetches four corners, runs up to four face tests and produces the result.
// ----------------------------------------------------------------------------
`default_nettype none
module pitm_ctrl (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    input  wire logic [pitm_pkg::OpW-1:0]  in_op,
    output logic                           in_ready,
    input  wire logic                      out_ready,
    output logic                           out_valid,
    output logic                           out_inside,
    input  wire pitm_pkg::pitm_sts_t       sts,
    output pitm_pkg::pitm_cmd_t            cmd
);
    import pitm_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_CHECK = 7'b0000010,
        S_TET   = 7'b0000100,
        S_VTX   = 7'b0001000,
        S_FACE  = 7'b0010000,
        S_WAIT  = 7'b0100000,
        S_OUT   = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic [2:0] cnt_reg, cnt_next;
    logic [1:0] face_reg, face_next;
    logic inside_reg, inside_next;

    assign in_ready = state_reg == S_IDLE;
    assign out_valid = state_reg == S_OUT;
    assign out_inside = inside_reg;

    always_comb
    begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        face_next = face_reg;
        inside_next = inside_reg;
        cmd = '0;
        cmd.face = face_reg;
        cmd.corner = cnt_reg[1:0];
        cmd.grab_corner = 2'(cnt_reg - 3'd1);
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && op_t'(in_op) == OP_QUERY)
                begin
                    cmd.capture = 1'b1;
                    cmd.clear_scan = 1'b1;
                    inside_next = 1'b0;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (sts.empty)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    cmd.tet_rd = 1'b1;
                    state_next = S_TET;
                end
            end
            S_TET:
            begin
                cnt_next = '0;
                state_next = S_VTX;
            end
            S_VTX:
            begin
                // Reads corner cnt while grabbing corner cnt-1.
                cmd.vtx_rd = cnt_reg < 3'd4;
                cmd.grab = cnt_reg != 3'd0;
                cnt_next = cnt_reg + 3'd1;
                if (cnt_reg == 3'd4)
                begin
                    face_next = '0;
                    state_next = S_FACE;
                end
            end
            S_FACE:
            begin
                cmd.face_start = 1'b1;
                state_next = S_WAIT;
            end
            S_WAIT:
            begin
                if (sts.det_done)
                begin
                    if (sts.det_neg)
                    begin
                        cmd.next_tet = 1'b1;
                        state_next = sts.last_tet ? S_OUT : S_CHECK;
                    end
                    else if (face_reg == 2'd3)
                    begin
                        inside_next = 1'b1;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        face_next = face_reg + 2'd1;
                        state_next = S_FACE;
                    end
                end
            end
            S_OUT:
            begin
                if (out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg <= '0;
            face_reg <= '0;
            inside_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            face_reg <= face_next;
            inside_reg <= inside_next;
        end
    end
endmodule
`default_nettype wire

FILE: hw/rtl/point_in_tet_mesh_classifier.sv
// ----------------------------------------------------------------------------
// point_in_tet_mesh_classifier: first containing tetrahedron of a query point
// Loads fill the vertex and tetrahedron memories; a query scans the mesh.
// ----------------------------------------------------------------------------
// Load requests are taken one a cycle while no query is in flight. When nothing is
// scanned, a query result is offered after the empty check; else each tetrahedron
// tested takes an entry read, a corner fetch and up to four face tests (12 products
// on one shared multiplier each); a miss stops at its first negative face.
// One request at a time; the next is taken once the result leaves.
// Reset clears control state, pore counter and tet_count; the mesh stays undefined.
`default_nettype none
module point_in_tet_mesh_classifier #(
    parameter int unsigned MAX_VERTICES = 4096,
    parameter int unsigned MAX_TETS = 4096,
    parameter int unsigned COORD_BITS = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    pitm_stream_if.sink      in_ch,
    pitm_stream_if.source    out_ch,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [1:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);
    import pitm_pkg::*;

    // The input payload carries the fields in the order of the request format.
    logic [OpW-1:0] operation;
    logic [IdxW-1:0] index;
    logic [COORD_BITS-1:0] coord_x, coord_y, coord_z;
    logic [IdxW-1:0] corner_a, corner_b, corner_c, corner_d;
    logic [TypeW-1:0] point_type;

    assign operation  = in_ch.data.operation;
    assign index      = in_ch.data.index;
    assign coord_x    = in_ch.data.coord_x;
    assign coord_y    = in_ch.data.coord_y;
    assign coord_z    = in_ch.data.coord_z;
    assign corner_a   = in_ch.data.corner_a;
    assign corner_b   = in_ch.data.corner_b;
    assign corner_c   = in_ch.data.corner_c;
    assign corner_d   = in_ch.data.corner_d;
    assign point_type = in_ch.data.point_type;

    // Configuration: a single register, tet_count, at byte address zero.
    logic [CntW-1:0] tet_count_reg;
    assign pready = 1'b1;
    assign prdata = (paddr == 2'd0) ? 32'(tet_count_reg) : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tet_count_reg <= '0;
        end
        else if (psel && penable && pwrite && paddr == 2'd0)
        begin
            tet_count_reg <= pwdata[CntW-1:0];
        end
    end

    pitm_cmd_t cmd;
    pitm_sts_t sts;
    logic in_fire, ctrl_ready, out_inside;
    logic [IdxW-1:0] scan_idx;
    logic [TypeW-1:0] type_reg;
    logic [PoreW-1:0] pore_reg;
    logic out_valid_q;

    assign in_fire = in_ch.valid && in_ch.ready;
    assign in_ch.ready = ctrl_ready;

    pitm_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_ch.valid), .in_op(operation), .in_ready(ctrl_ready),
        .out_ready(out_ch.ready), .out_valid(out_valid_q), .out_inside(out_inside),
        .sts(sts), .cmd(cmd)
    );

    pitm_datapath #(
        .MAX_VERTICES(MAX_VERTICES), .MAX_TETS(MAX_TETS), .CW(COORD_BITS)
    ) u_dp (
        .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .in_op(operation),
        .in_index(index), .in_point({coord_z, coord_y, coord_x}),
        .in_corners({corner_d, corner_c, corner_b, corner_a}),
        .tet_count(tet_count_reg), .cmd(cmd), .sts(sts), .scan_idx(scan_idx)
    );

    // The type code is kept from the query; the pore counter advances when the
    // result of an inside point is delivered, so the shown total already counts it.
    logic out_fire;
    assign out_fire = out_valid_q && out_ch.ready;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            type_reg <= point_type;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pore_reg <= '0;
        end
        else if (out_fire && out_inside && pore_reg != {PoreW{1'b1}})
        begin
            pore_reg <= pore_reg + 1'b1;
        end
    end

    assign out_ch.valid = out_valid_q;
    assign out_ch.data.inside_res = out_inside;
    assign out_ch.data.hit_tet = out_inside ? scan_idx : '0;
    assign out_ch.data.new_type = (out_inside && type_reg != 8'hFF) ? type_reg + 1'b1 : type_reg;
    assign out_ch.data.pore_total = (out_inside && pore_reg != {PoreW{1'b1}})
        ? pore_reg + 1'b1 : pore_reg;
endmodule
`default_nettype wire
